// ----- hw/rtl/dsuf_pkg.sv -----
// shared types and codes for the union-find engine
package dsuf_pkg;

  localparam int ElemW = 8;
  localparam int SizeW = 9;

  localparam logic [1:0] ModeMake  = 2'd0;
  localparam logic [1:0] ModeFind  = 2'd1;
  localparam logic [1:0] ModeUnion = 2'd2;

  localparam logic [1:0] StOk        = 2'd0;
  localparam logic [1:0] StNotMember = 2'd1;
  localparam logic [1:0] StIsMember  = 2'd2;
  localparam logic [1:0] StSameSet   = 2'd3;

  typedef struct packed {
    logic [1:0]       mode;
    logic [ElemW-1:0] elem_a;
    logic [ElemW-1:0] elem_b;
  } req_t;

  typedef struct packed {
    logic [ElemW-1:0] leader;
    logic [SizeW-1:0] set_size;
    logic [1:0]       status;
  } rsp_t;

endpackage

// ----- hw/rtl/disjoint_set_union_find.sv -----
// union-find engine with linked member lists and weighted union
//
// One request is taken at a time; in_stall_o stays high from the transfer of a request until
// its result has been transferred out. Mode 3 and rejected requests go straight to the result;
// make-set writes the stores in S_MAKE; find and make on a member read the leader and then its
// set size (S_LEAD1, S_LEAD2); union reads both leaders (S_UA, S_UB) and answers there within
// one set, else links the member lists (S_UC) and relabels the smaller set in S_WALK. The
// relabel walk takes one leader-store write and one next-link read per cycle. Valid marks clear
// at reset; the other stores need no clearing. Indices at or above ELEMENTS (or above 255)
// are never members, so storage depth is the smaller of ELEMENTS and 256.
module disjoint_set_union_find #(
  parameter int ELEMENTS = 256
) (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          in_valid_i,
  output logic          in_stall_o,
  input  dsuf_pkg::req_t in_data_i,
  output logic          out_valid_o,
  input  logic          out_stall_i,
  output dsuf_pkg::rsp_t out_data_o
);
  import dsuf_pkg::*;

  localparam int Reach = (ELEMENTS < 256) ? ELEMENTS : 256;
  localparam int AW    = $clog2(Reach);
  localparam int LW    = $clog2(Reach + 1);

  typedef enum logic [3:0] {
    S_IDLE, S_LEAD1, S_LEAD2, S_MAKE, S_UA, S_UB, S_UC, S_WALK, S_OUT
  } state_e;

  state_e         state_q;
  logic [1:0]     mode_q;
  logic [AW-1:0]  a_q, b_q;
  logic [AW-1:0]  x_q, y_q, big_q, small_q;
  logic [LW-1:0]  lenx_q, size_q;
  logic [AW-1:0]  lastx_q;
  logic [1:0]     status_q;
  logic           first_q;
  rsp_t           res_q;
  logic [Reach-1:0] valid_q;

  // stores
  logic [AW-1:0]  lo_mem [Reach];
  logic [AW:0]    nm_mem [Reach];
  logic [LW-1:0]  sl_mem [Reach];
  logic [AW-1:0]  la_mem [Reach];
  logic [AW-1:0]  lo_rd_q;
  logic [AW:0]    nm_rd_q;
  logic [LW-1:0]  sl_rd_q;
  logic [AW-1:0]  la_rd_q;

  logic [AW-1:0]  lo_raddr, nm_raddr, sl_raddr, la_raddr;
  logic           lo_we, nm_we, sl_we, la_we;
  logic [AW-1:0]  lo_waddr, nm_waddr, sl_waddr, la_waddr;
  logic [AW-1:0]  lo_wdata, la_wdata;
  logic [AW:0]    nm_wdata;
  logic [LW-1:0]  sl_wdata;

  logic           accept;
  logic           a_in_range, b_in_range, a_mem, b_mem;
  logic [AW-1:0]  a_idx, b_idx;
  logic           swap;
  logic [AW-1:0]  big_c, small_c, lastbig_c, lastsmall_c;
  logic [LW-1:0]  sum_c;
  logic [AW-1:0]  n_sel;
  logic           walk_done;

  assign accept      = in_valid_i && !in_stall_o;
  assign in_stall_o  = (state_q != S_IDLE);
  assign out_valid_o = (state_q == S_OUT);
  assign out_data_o  = res_q;

  assign a_in_range = (int'(in_data_i.elem_a) < Reach);
  assign b_in_range = (int'(in_data_i.elem_b) < Reach);
  assign a_idx      = in_data_i.elem_a[AW-1:0];
  assign b_idx      = in_data_i.elem_b[AW-1:0];
  assign a_mem      = a_in_range && valid_q[a_idx];
  assign b_mem      = b_in_range && valid_q[b_idx];

  // weighted union choice, tie keeps the set of elem_a
  assign swap        = (lenx_q < sl_rd_q);
  assign big_c       = swap ? y_q : x_q;
  assign small_c     = swap ? x_q : y_q;
  assign lastbig_c   = swap ? la_rd_q : lastx_q;
  assign lastsmall_c = swap ? lastx_q : la_rd_q;
  assign sum_c       = lenx_q + sl_rd_q;

  assign n_sel     = first_q ? small_q : nm_rd_q[AW-1:0];
  assign walk_done = !first_q && nm_rd_q[AW];

  always_comb begin
    lo_raddr = a_q;
    nm_raddr = n_sel;
    sl_raddr = lo_rd_q;
    la_raddr = lo_rd_q;
    lo_we    = 1'b0;
    nm_we    = 1'b0;
    sl_we    = 1'b0;
    la_we    = 1'b0;
    lo_waddr = a_q;
    nm_waddr = a_q;
    sl_waddr = a_q;
    la_waddr = a_q;
    lo_wdata = a_q;
    nm_wdata = {1'b1, AW'(0)};
    sl_wdata = LW'(1);
    la_wdata = a_q;
    unique case (state_q)
      S_IDLE: lo_raddr = a_idx;
      S_MAKE: begin
        lo_we = 1'b1;
        nm_we = 1'b1;
        sl_we = 1'b1;
        la_we = 1'b1;
      end
      S_UA: lo_raddr = b_q;
      S_UC: begin
        nm_we    = 1'b1;
        nm_waddr = lastbig_c;
        nm_wdata = {1'b0, small_c};
        sl_we    = 1'b1;
        sl_waddr = big_c;
        sl_wdata = sum_c;
        la_we    = 1'b1;
        la_waddr = big_c;
        la_wdata = lastsmall_c;
      end
      S_WALK: begin
        lo_we    = !walk_done;
        lo_waddr = n_sel;
        lo_wdata = big_q;
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk_i) begin
    if (lo_we) lo_mem[lo_waddr] <= lo_wdata;
    lo_rd_q <= lo_mem[lo_raddr];
  end

  always_ff @(posedge clk_i) begin
    if (nm_we) nm_mem[nm_waddr] <= nm_wdata;
    nm_rd_q <= nm_mem[nm_raddr];
  end

  always_ff @(posedge clk_i) begin
    if (sl_we) sl_mem[sl_waddr] <= sl_wdata;
    sl_rd_q <= sl_mem[sl_raddr];
  end

  always_ff @(posedge clk_i) begin
    if (la_we) la_mem[la_waddr] <= la_wdata;
    la_rd_q <= la_mem[la_raddr];
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
      valid_q <= '0;
    end else begin
      unique case (state_q)
        S_IDLE: begin
          if (accept) begin
            mode_q <= in_data_i.mode;
            a_q    <= a_idx;
            b_q    <= b_idx;
            unique case (in_data_i.mode)
              ModeMake: begin
                if (!a_in_range) begin
                  res_q   <= '{leader: '0, set_size: '0, status: StNotMember};
                  state_q <= S_OUT;
                end else if (a_mem) begin
                  status_q <= StIsMember;
                  state_q  <= S_LEAD1;
                end else begin
                  state_q <= S_MAKE;
                end
              end
              ModeFind: begin
                if (!a_mem) begin
                  res_q   <= '{leader: '0, set_size: '0, status: StNotMember};
                  state_q <= S_OUT;
                end else begin
                  status_q <= StOk;
                  state_q  <= S_LEAD1;
                end
              end
              ModeUnion: begin
                if (!(a_mem && b_mem)) begin
                  res_q   <= '{leader: '0, set_size: '0, status: StNotMember};
                  state_q <= S_OUT;
                end else begin
                  state_q <= S_UA;
                end
              end
              default: begin
                res_q   <= '0;
                state_q <= S_OUT;
              end
            endcase
          end
        end
        S_LEAD1: begin
          x_q     <= lo_rd_q;
          state_q <= S_LEAD2;
        end
        S_LEAD2: begin
          res_q.leader   <= ElemW'(x_q);
          res_q.set_size <= SizeW'(sl_rd_q);
          res_q.status   <= status_q;
          state_q        <= S_OUT;
        end
        S_MAKE: begin
          valid_q[a_q]   <= 1'b1;
          res_q.leader   <= ElemW'(a_q);
          res_q.set_size <= SizeW'(1);
          res_q.status   <= StOk;
          state_q        <= S_OUT;
        end
        S_UA: begin
          x_q     <= lo_rd_q;
          state_q <= S_UB;
        end
        S_UB: begin
          y_q     <= lo_rd_q;
          lenx_q  <= sl_rd_q;
          lastx_q <= la_rd_q;
          if (lo_rd_q == x_q) begin
            res_q.leader   <= ElemW'(x_q);
            res_q.set_size <= SizeW'(sl_rd_q);
            res_q.status   <= StSameSet;
            state_q        <= S_OUT;
          end else begin
            state_q <= S_UC;
          end
        end
        S_UC: begin
          big_q   <= big_c;
          small_q <= small_c;
          size_q  <= sum_c;
          first_q <= 1'b1;
          state_q <= S_WALK;
        end
        S_WALK: begin
          first_q <= 1'b0;
          if (walk_done) begin
            res_q.leader   <= ElemW'(big_q);
            res_q.set_size <= SizeW'(size_q);
            res_q.status   <= StOk;
            state_q        <= S_OUT;
          end
        end
        S_OUT: begin
          if (!out_stall_i) state_q <= S_IDLE;
        end
        default: state_q <= S_IDLE;
      endcase
    end
  end

  a_accept_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    accept |=> in_stall_o)
    else $error("request transfer did not lock the input");

  a_walk_member: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_WALK) && !walk_done |-> valid_q[n_sel])
    else $error("relabel walk reached a non-member");

  a_union_size: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && (mode_q == ModeUnion) && (res_q.status == StOk) |-> res_q.set_size >= 2)
    else $error("union result smaller than two members");

  a_notmember_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && (res_q.status == StNotMember) |-> (res_q.leader == '0)
      && (res_q.set_size == '0))
    else $error("rejected request reports a set");

endmodule
